[sv/multichannel_allpole_iir_filter_top_assert.svh]
// Assertion macros for the all-pole IIR filter checker
`ifndef MULTICHANNEL_ALLPOLE_IIR_FILTER_TOP_ASSERT_SVH
`define MULTICHANNEL_ALLPOLE_IIR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define APIIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("apiir assertion failed");

// Next-cycle implication, ignored while reset is held
`define APIIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("apiir assertion failed");

// Next-cycle implication that also covers reset itself
`define APIIR_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("apiir assertion failed");

`endif

[sv/apiir_pkg.sv]
package apiir_pkg;

    localparam int ORDER    = 4;
    localparam int CHANNELS = 8;

    localparam int NUM_REGS  = 5;
    localparam int COEF_W    = 18;
    localparam int SAMP_W    = 24;
    localparam int CHAN_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
    localparam int SAMP_MAX   = 8388607;
    localparam int SAMP_MIN   = -8388608;

    localparam int PROD_W = SAMP_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(ORDER + 1) + 1;
    localparam int ROW_W  = ORDER * SAMP_W;
    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_B0 = CFG_IDX_W'(0);
    localparam logic signed [COEF_W-1:0] GAIN_B0_RESET = COEF_W'(16384);

    // operation codes
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic signed [SAMP_W-1:0] SAMP_MAX_V = SAMP_W'(SAMP_MAX);
    localparam logic signed [SAMP_W-1:0] SAMP_MIN_V = SAMP_W'(SAMP_MIN);

    typedef struct packed {
        logic                     op;
        logic [CHAN_W-1:0]        channel;
        logic signed [SAMP_W-1:0] sample_in;
    } t_in_req;

    typedef struct packed {
        logic [CHAN_W-1:0]        channel_out;
        logic signed [SAMP_W-1:0] sample_out;
        logic                     saturated;
    } t_out_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM
    } t_state;

endpackage

[sv/apiir_ram.sv]
module apiir_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/multichannel_allpole_iir_filter_top.sv]
// Multichannel all-pole IIR filter (direct form). Each request names a channel
// and carries a Q1.23 sample; the block returns y = b0*x - sum a_k*y[n-k] for
// that channel, rounded to nearest (halves up) and saturated to 24 bits with a
// flag, and pushes y into the channel's history. A clear request (op = 1)
// empties every history and returns zero. Each channel's ORDER past outputs
// sit as one row of a single-port-read RAM; a row is read on acceptance,
// multiplied by all coefficients in parallel, summed, then written back.
// A request passes the RAM read, then the product registers, then sum,
// round, saturate and write-back, which wait while an untaken result holds
// the output register. The next request is accepted only once the previous
// one has written back, so a channel never reads a stale row. Histories are
// emptied through one valid bit per row, so reset and clear need no RAM sweep.
// Coefficients must only be written while the block is idle.
module multichannel_allpole_iir_filter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  apiir_pkg::t_in_req i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output apiir_pkg::t_out_res o_out_data,
    // coefficient write port
    input  logic                                 i_cfg_we,
    input  logic [apiir_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [apiir_pkg::COEF_W-1:0]         i_cfg_data
);

    import apiir_pkg::*;

    t_state r_state, n_state;

    // coefficients: b0 then a1..a4
    logic signed [COEF_W-1:0] r_coef [NUM_REGS];

    t_in_req  r_req;
    t_out_res r_out;
    logic     r_out_valid;

    logic [CHANNELS-1:0]      r_row_valid;
    logic signed [PROD_W-1:0] r_prod [ORDER+1];

    logic              w_load;
    logic              w_accept;
    logic              w_in_range;
    logic [ADDR_W-1:0] w_row_addr;
    logic [ROW_W-1:0]  w_rd_row;
    logic [ROW_W-1:0]  w_hist;
    logic [ROW_W-1:0]  w_new_row;
    logic              w_we;

    logic signed [SAMP_W-1:0] w_tap      [ORDER];
    logic signed [COEF_W-1:0] w_coef_tap [ORDER];

    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_scaled;
    logic signed [SAMP_W-1:0] w_y;
    logic                     w_sat;

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                // hold the products until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------
    // Coefficient registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[REG_GAIN_B0] <= GAIN_B0_RESET;
        end else if (i_cfg_we && (int'(i_cfg_index) < NUM_REGS)) begin
            r_coef[i_cfg_index] <= signed'(i_cfg_data);
        end
    end

    // feedback taps past the last register have a zero coefficient
    for (genvar p = 0; p < ORDER; p++) begin : g_tap_coef
        if (p + 1 < NUM_REGS) begin : g_reg
            assign w_coef_tap[p] = r_coef[p+1];
        end else begin : g_zero
            assign w_coef_tap[p] = '0;
        end
    end

    // ---------------------------------------------------------------
    // History RAM: one row per channel, entry 0 = y[n-1] in the low bits
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
    end

    assign w_in_range = (int'(r_req.channel) < CHANNELS);
    assign w_row_addr = ADDR_W'(r_req.channel);
    assign w_we = w_load && (r_req.op == OP_FILTER) && w_in_range;

    apiir_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_row_addr),
        .i_wdata (w_new_row),
        .i_re    (w_accept),
        .i_raddr (ADDR_W'(i_in_data.channel)),
        .o_rdata (w_rd_row)
    );

    // a row never written since reset or the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (w_load && (r_req.op == OP_CLEAR)) begin
            r_row_valid <= '0;
        end else if (w_we) begin
            r_row_valid[w_row_addr] <= 1'b1;
        end
    end

    assign w_hist = (w_in_range && r_row_valid[w_row_addr]) ? w_rd_row : '0;

    // ---------------------------------------------------------------
    // Products, registered
    // ---------------------------------------------------------------
    always_comb begin
        for (int p = 0; p < ORDER; p++) begin
            w_tap[p] = signed'(w_hist[p*SAMP_W +: SAMP_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod[0] <= PROD_W'(r_req.sample_in) * PROD_W'(r_coef[REG_GAIN_B0]);
            for (int p = 0; p < ORDER; p++) begin
                r_prod[p+1] <= PROD_W'(w_tap[p]) * PROD_W'(w_coef_tap[p]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sum, round to Q1.23, saturate, new history row
    // ---------------------------------------------------------------
    always_comb begin
        w_acc = ACC_W'(r_prod[0]);
        for (int p = 1; p <= ORDER; p++) begin
            w_acc = w_acc - ACC_W'(r_prod[p]);
        end
        w_scaled = (w_acc + ACC_W'(ROUND_BIAS)) >>> FRAC_SHIFT;
        if (w_scaled > ACC_W'(SAMP_MAX)) begin
            w_y   = SAMP_MAX_V;
            w_sat = 1'b1;
        end else if (w_scaled < ACC_W'(SAMP_MIN)) begin
            w_y   = SAMP_MIN_V;
            w_sat = 1'b1;
        end else begin
            w_y   = SAMP_W'(w_scaled);
            w_sat = 1'b0;
        end
    end

    always_comb begin
        w_new_row = '0;
        w_new_row[0 +: SAMP_W] = w_y;
        for (int p = 1; p < ORDER; p++) begin
            w_new_row[p*SAMP_W +: SAMP_W] = w_hist[(p-1)*SAMP_W +: SAMP_W];
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.channel_out <= r_req.channel;
            if ((r_req.op == OP_FILTER) && w_in_range) begin
                r_out.sample_out <= w_y;
                r_out.saturated  <= w_sat;
            end else begin
                r_out.sample_out <= '0;
                r_out.saturated  <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/apiir_checker.sv]
`include "multichannel_allpole_iir_filter_top_assert.svh"

module apiir_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input apiir_pkg::t_out_res                   o_out_data,
    input logic                                  i_cfg_we
);

    import apiir_pkg::*;

    logic w_at_rail;

    // clipped results sit on one of the two rails
    assign w_at_rail = (o_out_data.sample_out == SAMP_MAX_V)
                    || (o_out_data.sample_out == SAMP_MIN_V);

    // reset leaves no result pending and the block ready
    `APIIR_ASSERT_RST(a_reset_state, !i_rst_n, !o_out_valid && o_in_ready)

    // one request in flight: accepting one drops ready next cycle
    `APIIR_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled result is held
    `APIIR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // saturation flag only with a clipped value
    `APIIR_ASSERT_NOW(a_sat_clip, o_out_valid && o_out_data.saturated, w_at_rail)

    // coefficients change only while nothing is in flight
    `APIIR_ASSERT_NOW(a_cfg_idle, i_cfg_we, o_in_ready && !o_out_valid)

endmodule

bind multichannel_allpole_iir_filter_top apiir_checker u_apiir_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the multichannel all-pole IIR filter.
// A behavioural model of the filter (per-channel output history, coefficient
// copy, round-half-up and 24-bit clipping) runs alongside the block. Each
// accepted request is pushed through the model, and the sample it predicts is
// queued. Every result taken from the block is compared field by field with
// the oldest queued sample.
// The run has short directed tests first: pass-through at reset values,
// rounding and clipping, feedback and clearing. Random phases follow, each with
// its own coefficient set. Then back-pressure with a drain pause, more random
// phases, and a final phase with no idling on either side.
module tb_top;
    import apiir_pkg::*;

    // register indexes beyond the gain, which the package already names
    localparam logic [CFG_IDX_W-1:0] REG_FB_A1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FB_A2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FB_A3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_FB_A4 = CFG_IDX_W'(4);
    localparam int MAX_CFG_IDX = (1 << CFG_IDX_W) - 1;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MINUS_ONE = -COEF_W'(16384);

    localparam int BURST_MAX       = 19;   // longest idle burst, either side
    localparam int REPORT_LIMIT    = 10;   // mismatches printed in full
    localparam int PHASE_ITEMS     = 95;
    localparam int HOLD_ITEMS      = 30;
    localparam int HOLD_CYCLES     = 400;
    localparam int FINAL_ITEMS     = 150;
    localparam int TAIL_CYCLES     = 8;

    // shapes of the coefficient set used for a random phase
    typedef enum int {
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_GAIN_ONLY,
        SET_WILD,
        SET_STABLE
    } t_coef_shape;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_req              i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_res             o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0]    i_cfg_data  = '0;

    multichannel_allpole_iir_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Filter model state: coefficients as the block holds them, and each
    // channel's past outputs, newest first.
    logic signed [COEF_W-1:0] coef_copy [NUM_REGS];
    logic signed [SAMP_W-1:0] hist_copy [CHANNELS][ORDER];

    // coefficient set to be loaded next, indexed by register index
    logic signed [COEF_W-1:0] coef_set [NUM_REGS];

    // predicted filter outputs, oldest first
    t_out_res filter_out_q [$];

    int  mismatches    = 0;
    int  requests_sent = 0;
    int  clears_sent   = 0;
    int  results_seen  = 0;
    int  clipped_seen  = 0;
    int  coef_loads    = 0;
    bit  idle_on       = 1'b1;
    int  sink_hold_req = 0;   // long hold-off handed to the result sink

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop, well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Filter model: one request in, the result it should give out.
    // ------------------------------------------------------------------
    function automatic t_out_res run_iir(t_in_req req);
        t_out_res res;
        longint   acc;
        longint   y;
        int       k;
        res.channel_out = req.channel;
        res.sample_out  = '0;
        res.saturated   = 1'b0;
        if (req.op == OP_CLEAR) begin
            foreach (hist_copy[c, t]) hist_copy[c][t] = '0;
            return res;
        end
        // exact Q5.37 products, summed in 64 bits
        acc = longint'(req.sample_in) * longint'(coef_copy[REG_GAIN_B0]);
        for (k = 0; k < ORDER; k++) begin
            if (k + 1 < NUM_REGS)
                acc -= longint'(coef_copy[k + 1]) * longint'(hist_copy[req.channel][k]);
        end
        // round half up, then clip to Q1.23
        y = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
        if (y > SAMP_MAX) begin
            y = SAMP_MAX;
            res.saturated = 1'b1;
        end else if (y < SAMP_MIN) begin
            y = SAMP_MIN;
            res.saturated = 1'b1;
        end
        for (k = ORDER - 1; k > 0; k--)
            hist_copy[req.channel][k] = hist_copy[req.channel][k - 1];
        hist_copy[req.channel][0] = SAMP_W'(y);
        res.sample_out = SAMP_W'(y);
        return res;
    endfunction

    function automatic t_in_req make_req(logic op, int ch, int samp);
        t_in_req req;
        req.op        = op;
        req.channel   = CHAN_W'(ch);
        req.sample_in = SAMP_W'(samp);
        return req;
    endfunction

    // Random request: mostly filtering, the odd clear, samples biased
    // towards the extremes and small values.
    function automatic t_in_req rand_request();
        t_in_req req;
        req.op      = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_FILTER;
        req.channel = CHAN_W'($urandom);
        case ($urandom_range(0, 7))
            0:       req.sample_in = SAMP_MAX_V;
            1:       req.sample_in = SAMP_MIN_V;
            2:       req.sample_in = SAMP_W'($urandom_range(0, 512) - 256);
            default: req.sample_in = SAMP_W'($urandom);
        endcase
        return req;
    endfunction

    function automatic void choose_coefs();
        t_coef_shape shape;
        shape = $urandom_range(0, 1) ? SET_STABLE : t_coef_shape'($urandom_range(0, 3));
        foreach (coef_set[r]) begin
            case (shape)
                SET_ALL_MAX:   coef_set[r] = COEF_MAX;
                SET_ALL_MIN:   coef_set[r] = COEF_MIN;
                SET_GAIN_ONLY: coef_set[r] = (r == REG_GAIN_B0) ? COEF_W'($urandom) : '0;
                SET_WILD:      coef_set[r] = COEF_W'($urandom);
                default: begin
                    // gain within +-2.0, feedback within +-0.25: stays stable
                    if (r == REG_GAIN_B0)
                        coef_set[r] = COEF_W'($urandom_range(0, 65535) - 32768);
                    else
                        coef_set[r] = COEF_W'($urandom_range(0, 8192) - 4096);
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offers one request, optionally after an idle burst, and leaves valid
    // high so that a following request can go straight on.
    task automatic send_request(t_in_req req);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        filter_out_q.push_back(run_iir(req));
        requests_sent++;
        if (req.op == OP_CLEAR)
            clears_sent++;
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (filter_out_q.size() != 0);
    endtask

    // Write enable is left high; load_coefs lowers it after the last write.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx < NUM_REGS)
            coef_copy[idx] = val;
    endtask

    task automatic load_coefs();
        wait_drained();
        cfg_write(REG_GAIN_B0, coef_set[REG_GAIN_B0]);
        cfg_write(REG_FB_A1, coef_set[REG_FB_A1]);
        cfg_write(REG_FB_A2, coef_set[REG_FB_A2]);
        cfg_write(REG_FB_A3, coef_set[REG_FB_A3]);
        cfg_write(REG_FB_A4, coef_set[REG_FB_A4]);
        // writes to unused indexes must leave the coefficients alone
        if ($urandom_range(0, 1))
            cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, MAX_CFG_IDX)), COEF_W'($urandom));
        i_cfg_we <= 1'b0;
        coef_loads++;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each accepted result, drive ready with random
    // stall bursts and, on request, one long hold-off.
    // ------------------------------------------------------------------
    task automatic check_result(t_out_res got);
        t_out_res want;
        results_seen++;
        if (got.saturated)
            clipped_seen++;
        if (filter_out_q.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
                $display("%0t: result with no request pending: ch %0d sample %0d sat %0b",
                         $realtime, got.channel_out, got.sample_out, got.saturated);
            mismatches++;
            return;
        end
        want = filter_out_q.pop_front();
        if (got.channel_out !== want.channel_out || got.sample_out !== want.sample_out
                || got.saturated !== want.saturated) begin
            if (mismatches < REPORT_LIMIT)
                $display({"%0t: mismatch: expected ch %0d sample %0d sat %0b, ",
                          "got ch %0d sample %0d sat %0b"},
                         $realtime, want.channel_out, want.sample_out, want.saturated,
                         got.channel_out, got.sample_out, got.saturated);
            mismatches++;
        end
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                check_result(o_out_data);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left  = $urandom_range(1, BURST_MAX) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset coefficients are unity gain and no feedback, so every sample
    // should come straight through.
    task automatic test_reset_passthrough();
        send_request(make_req(OP_FILTER, 0, SAMP_MAX));
        send_request(make_req(OP_FILTER, CHANNELS - 1, SAMP_MIN));
        send_request(make_req(OP_FILTER, 3, 0));
        send_request(make_req(OP_FILTER, 5, 1));
        send_request(make_req(OP_FILTER, 2, -1));
    endtask

    // Smallest gain exposes the rounding: halves go towards plus infinity.
    // Extreme gains on extreme samples clip in both directions.
    task automatic test_rounding_clipping();
        coef_set = '{default: '0};
        coef_set[REG_GAIN_B0] = COEF_W'(1);
        load_coefs();
        send_request(make_req(OP_FILTER, 1, ROUND_BIAS));
        send_request(make_req(OP_FILTER, 1, -ROUND_BIAS));
        send_request(make_req(OP_FILTER, 1, ROUND_BIAS - 1));
        send_request(make_req(OP_FILTER, 1, -ROUND_BIAS - 1));
        coef_set[REG_GAIN_B0] = COEF_MAX;
        load_coefs();
        send_request(make_req(OP_FILTER, 4, SAMP_MAX));
        send_request(make_req(OP_FILTER, 4, SAMP_MIN));
        coef_set[REG_GAIN_B0] = COEF_MIN;
        load_coefs();
        send_request(make_req(OP_FILTER, 6, SAMP_MIN));
        send_request(make_req(OP_FILTER, 6, SAMP_MAX));
    endtask

    // a1 = -1.0 makes an integrator, so the history shows in the output;
    // a clear in the middle must zero it. Then taps a2..a4 at extremes.
    task automatic test_feedback_clear();
        coef_set = '{default: '0};
        coef_set[REG_GAIN_B0] = GAIN_B0_RESET;
        coef_set[REG_FB_A1]   = COEF_MINUS_ONE;
        load_coefs();
        send_request(make_req(OP_CLEAR, 0, 0));
        send_request(make_req(OP_FILTER, CHANNELS - 1, 1000));
        send_request(make_req(OP_FILTER, CHANNELS - 1, 1000));
        send_request(make_req(OP_FILTER, CHANNELS - 1, 1000));
        send_request(make_req(OP_FILTER, 0, 500));
        send_request(make_req(OP_CLEAR, CHANNELS - 1, SAMP_MIN));
        send_request(make_req(OP_FILTER, CHANNELS - 1, 1000));
        coef_set[REG_FB_A2] = COEF_MIN;
        coef_set[REG_FB_A3] = COEF_MAX;
        coef_set[REG_FB_A4] = COEF_MAX;
        load_coefs();
        send_request(make_req(OP_FILTER, CHANNELS - 1, 2000));
        send_request(make_req(OP_FILTER, CHANNELS - 1, -3000));
        send_request(make_req(OP_FILTER, CHANNELS - 1, 4000));
    endtask

    task automatic test_random_phases(int phases);
        repeat (phases) begin
            choose_coefs();
            load_coefs();
            repeat (PHASE_ITEMS) send_request(rand_request());
        end
    endtask

    // The sink holds off for a long stretch while requests keep coming, so
    // the block fills and stalls its input; then the sender pauses until
    // everything has drained before going on.
    task automatic test_backpressure();
        wait_drained();
        sink_hold_req = HOLD_CYCLES;
        repeat (HOLD_ITEMS) send_request(rand_request());
        wait_drained();
        repeat (HOLD_ITEMS) send_request(rand_request());
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        choose_coefs();
        load_coefs();
        repeat (FINAL_ITEMS) send_request(rand_request());
    endtask

    initial begin
        // model starts from the reset state of the block
        foreach (hist_copy[c, t]) hist_copy[c][t] = '0;
        coef_copy = '{default: '0};
        coef_copy[REG_GAIN_B0] = GAIN_B0_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_passthrough();
        test_rounding_clipping();
        test_feedback_clear();
        test_random_phases(4);
        test_backpressure();
        test_random_phases(4);
        test_full_rate();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d clears) over %0d coefficient sets.",
                 requests_sent, clears_sent, coef_loads);
        $display("Checked %0d results, %0d of them clipped; %0d mismatches.",
                 results_seen, clipped_seen, mismatches);
        if (mismatches == 0 && filter_out_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/apiir_pkg.sv
sv/apiir_ram.sv
sv/multichannel_allpole_iir_filter_top.sv
sv/apiir_checker.sv
test/tb_top.sv
